// ===== rtl/m3i_pkg.sv =====
// Shared types and constants for the 3x3 matrix inverse core.
// No dependencies.
`default_nettype none

package m3i_pkg;

    localparam int MSIZE = 3;
    localparam int NENT  = MSIZE * MSIZE;

    // Per-lane status from the divider lanes.
    typedef struct packed {
        logic singular;
        logic saturated;
    } status_t;

endpackage

`default_nettype wire

// ===== rtl/m3i_div.sv =====
// Pipelined restoring divider lane: rounded, saturated cofactor / determinant.
// Depends on m3i_pkg (status_t). Stages advance only while adv is high.
`default_nettype none

module m3i_div #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  wire                              clk,
    input  wire                              adv,
    input  wire logic signed [2*DATA_WIDTH:0] num,
    input  wire logic signed [3*DATA_WIDTH:0] den,
    output logic signed [DATA_WIDTH-1:0]     quo,
    output m3i_pkg::status_t                 status
);

    localparam int W   = DATA_WIDTH;
    localparam int NW  = 2 * W + 2 * FRAC_BITS;   // |num| << 2F
    localparam int DW  = 3 * W;                   // |den|
    localparam int QB  = W + 1;                   // quotient bits kept
    localparam int RW  = ((NW > DW + QB) ? NW : DW + QB) + 1;
    localparam logic [QB:0] HALF = (QB + 1)'(1) << (W - 1);

    // prep stage
    logic [NW-1:0] n0_reg, n0_next;
    logic [DW-1:0] d0_reg, d0_next;
    logic          neg0_reg, neg0_next, zero0_reg, zero0_next;

    // division steps, index 0 is the setup stage
    logic [RW-1:0] rem_reg  [QB+1];
    logic [RW-1:0] rem_next [QB+1];
    logic [QB-1:0] q_reg    [QB+1];
    logic [QB-1:0] q_next   [QB+1];
    logic [DW-1:0] d_reg    [QB+1];
    logic [QB:0]   neg_reg, ovf_reg, zero_reg;
    logic [QB:0]   neg_next, ovf_next, zero_next;

    // rounding stage
    logic [QB:0] qr_reg, qr_next;
    logic        negr_reg, ovfr_reg, zeror_reg;

    // output stage
    logic [W-1:0]     quo_reg, quo_next;
    m3i_pkg::status_t st_reg, st_next;

    logic [2*W:0] num_abs;

    always_comb
    begin
        num_abs    = num[2*W] ? (2*W+1)'(-num) : (2*W+1)'(num);
        n0_next    = NW'(num_abs[2*W-1:0]) << (2 * FRAC_BITS);
        d0_next    = den[3*W] ? DW'(-den) : DW'(den);
        neg0_next  = num[2*W] ^ den[3*W];
        zero0_next = (den == '0);
    end

    always_comb
    begin
        rem_next[0]  = RW'(n0_reg);
        q_next[0]    = '0;
        ovf_next[0]  = RW'(n0_reg) >= (RW'(d0_reg) << QB);
        neg_next[0]  = neg0_reg;
        zero_next[0] = zero0_reg;
    end

    for (genvar s = 0; s < QB; s++)
    begin : g_step
        localparam int K = QB - 1 - s;
        logic [RW-1:0] dk;
        always_comb
        begin
            dk = RW'(d_reg[s]) << K;
            if (rem_reg[s] >= dk)
            begin
                rem_next[s+1] = rem_reg[s] - dk;
                q_next[s+1]   = q_reg[s] | (QB'(1) << K);
            end
            else
            begin
                rem_next[s+1] = rem_reg[s];
                q_next[s+1]   = q_reg[s];
            end
            neg_next[s+1]  = neg_reg[s];
            ovf_next[s+1]  = ovf_reg[s];
            zero_next[s+1] = zero_reg[s];
        end
    end

    always_comb
    begin
        qr_next = (QB + 1)'(q_reg[QB])
                + (QB + 1)'((rem_reg[QB] << 1) >= RW'(d_reg[QB]));
    end

    // saturate, apply sign, clear on a singular matrix
    always_comb
    begin
        logic [QB:0] lim;
        lim = negr_reg ? HALF : HALF - (QB + 1)'(1);
        st_next.singular  = zeror_reg;
        st_next.saturated = 1'b0;
        if (zeror_reg)
        begin
            quo_next = '0;
        end
        else if (ovfr_reg || (qr_reg > lim))
        begin
            quo_next          = W'(lim);
            st_next.saturated = 1'b1;
        end
        else
        begin
            quo_next = negr_reg ? W'(-qr_reg) : W'(qr_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            n0_reg    <= n0_next;
            d0_reg    <= d0_next;
            neg0_reg  <= neg0_next;
            zero0_reg <= zero0_next;
            d_reg[0]  <= d0_reg;
            for (int s = 1; s <= QB; s++)
            begin
                d_reg[s] <= d_reg[s-1];
            end
            for (int s = 0; s <= QB; s++)
            begin
                rem_reg[s] <= rem_next[s];
                q_reg[s]   <= q_next[s];
            end
            neg_reg   <= neg_next;
            ovf_reg   <= ovf_next;
            zero_reg  <= zero_next;
            qr_reg    <= qr_next;
            negr_reg  <= neg_reg[QB];
            ovfr_reg  <= ovf_reg[QB];
            zeror_reg <= zero_reg[QB];
            quo_reg   <= quo_next;
            st_reg    <= st_next;
        end
    end

    assign quo    = $signed(quo_reg);
    assign status = st_reg;

endmodule

`default_nettype wire

// ===== rtl/matrix3x3_inverse_core.sv =====
// 3x3 fixed-point matrix inverse core, top level.
// Depends on m3i_pkg and m3i_div.
//
// Usage:
//   Request channel (req_valid / req_stall) carries one matrix a_00..a_22,
//   signed Q(DATA_WIDTH-FRAC_BITS).FRAC_BITS. A transaction completes on a
//   rising edge with req_valid high and req_stall low.
//   Response channel (rsp_valid / rsp_stall) carries inv_00..inv_22, the
//   inverse (adjugate over determinant, rounded half away from zero and
//   saturated), plus singular (determinant exactly zero, entries zero) and
//   saturated (some entry clipped).
//   Throughput: one matrix per cycle unless the response side stalls. The
//   pipeline is the eight-stage multiply/determinant front end followed by
//   the one-quotient-bit-per-stage divider lanes.
//   Reset clears all valid bits; payload registers are not reset.
//   A rsp_stall with rsp_valid high freezes the entire pipeline in place, and
//   req_stall is raised in the same cycle; nothing is dropped or repeated.
`default_nettype none

module matrix3x3_inverse_core #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          req_valid,
    output logic                         req_stall,
    input  wire logic signed [DATA_WIDTH-1:0] a_00,
    input  wire logic signed [DATA_WIDTH-1:0] a_01,
    input  wire logic signed [DATA_WIDTH-1:0] a_02,
    input  wire logic signed [DATA_WIDTH-1:0] a_10,
    input  wire logic signed [DATA_WIDTH-1:0] a_11,
    input  wire logic signed [DATA_WIDTH-1:0] a_12,
    input  wire logic signed [DATA_WIDTH-1:0] a_20,
    input  wire logic signed [DATA_WIDTH-1:0] a_21,
    input  wire logic signed [DATA_WIDTH-1:0] a_22,
    output logic                         rsp_valid,
    input  wire                          rsp_stall,
    output logic signed [DATA_WIDTH-1:0] inv_00,
    output logic signed [DATA_WIDTH-1:0] inv_01,
    output logic signed [DATA_WIDTH-1:0] inv_02,
    output logic signed [DATA_WIDTH-1:0] inv_10,
    output logic signed [DATA_WIDTH-1:0] inv_11,
    output logic signed [DATA_WIDTH-1:0] inv_12,
    output logic signed [DATA_WIDTH-1:0] inv_20,
    output logic signed [DATA_WIDTH-1:0] inv_21,
    output logic signed [DATA_WIDTH-1:0] inv_22,
    output logic                         singular,
    output logic                         saturated
);

    localparam int W       = DATA_WIDTH;
    localparam int N       = m3i_pkg::NENT;
    localparam int HB      = W / 2;                 // low half of a 2x2 operand
    localparam int HW      = W - HB;
    localparam int CW      = 2 * W + 1;             // cofactor width
    localparam int CH      = (CW + 3) / 4;          // chunk of cofactor for det
    localparam int PW      = W + CH + 1;            // det partial product
    localparam int DETW    = 3 * W + 1;             // determinant width
    localparam int FRONT   = 8;
    localparam int DIV_LAT = W + 5;
    localparam int VLEN    = FRONT + DIV_LAT;

    logic signed [W-1:0] a_in [N];
    assign a_in = '{a_00, a_01, a_02, a_10, a_11, a_12, a_20, a_21, a_22};

    // pipeline advance: everything moves unless the output is held
    logic adv;
    logic [VLEN-1:0] vld_reg, vld_next;

    assign adv       = !(vld_reg[VLEN-1] && rsp_stall);
    assign req_stall = !adv;
    assign rsp_valid = vld_reg[VLEN-1];
    assign vld_next  = {vld_reg[VLEN-2:0], req_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= vld_next;
        end
    end

    // T1: split products for the 2x2 minors; [k][0] main diagonal, [k][1] anti
    logic signed [W+HB:0]   plo_reg [N][2];
    logic signed [W+HB:0]   plo_next [N][2];
    logic signed [W+HW-1:0] phi_reg [N][2];
    logic signed [W+HW-1:0] phi_next [N][2];
    // T2: full products
    logic signed [2*W-1:0]  prod_reg [N][2];
    logic signed [2*W-1:0]  prod_next [N][2];
    // T3: signed cofactors
    logic signed [CW-1:0]   cof_reg [N];
    logic signed [CW-1:0]   cof_next [N];
    // row 0 delayed to meet its cofactors
    logic signed [W-1:0]    row0_reg [3][3];
    // T4..T8: cofactors travel alongside the determinant
    logic signed [CW-1:0]   cofd_reg [5][N];
    // T4: row 0 times cofactor chunks
    logic signed [PW-1:0]   dp_reg [3][4];
    logic signed [PW-1:0]   dp_next [3][4];
    // T5: chunk pairs, T6: Laplace terms, T7/T8: determinant
    logic signed [DETW-1:0] dq_reg [3][2];
    logic signed [DETW-1:0] dq_next [3][2];
    logic signed [DETW-1:0] term_reg [3];
    logic signed [DETW-1:0] term_next [3];
    logic signed [DETW-1:0] s01_reg, s01_next, t2_reg, det_reg, det_next;

    for (genvar r = 0; r < 3; r++)
    begin : g_row
        for (genvar c = 0; c < 3; c++)
        begin : g_col
            localparam int K  = r * 3 + c;
            localparam int R0 = (r == 0) ? 1 : 0;
            localparam int R1 = (r == 2) ? 1 : 2;
            localparam int C0 = (c == 0) ? 1 : 0;
            localparam int C1 = (c == 2) ? 1 : 2;
            localparam bit ODD = ((r + c) % 2) == 1;
            logic signed [W-1:0] x0, x1, y0, y1;
            always_comb
            begin
                x0 = a_in[R0*3+C0];
                x1 = a_in[R1*3+C1];
                y0 = a_in[R0*3+C1];
                y1 = a_in[R1*3+C0];
                plo_next[K][0] = x0 * $signed({1'b0, x1[HB-1:0]});
                phi_next[K][0] = x0 * $signed(x1[W-1:HB]);
                plo_next[K][1] = y0 * $signed({1'b0, y1[HB-1:0]});
                phi_next[K][1] = y0 * $signed(y1[W-1:HB]);
                // sign of the cofactor folded into the subtraction order
                if (ODD)
                begin
                    cof_next[K] = CW'(prod_reg[K][1]) - CW'(prod_reg[K][0]);
                end
                else
                begin
                    cof_next[K] = CW'(prod_reg[K][0]) - CW'(prod_reg[K][1]);
                end
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < N; k++)
        begin
            for (int p = 0; p < 2; p++)
            begin
                prod_next[k][p] = ((2*W)'(phi_reg[k][p]) <<< HB)
                                + (2*W)'(plo_reg[k][p]);
            end
        end
    end

    // T4..T8: det = sum over j of a_0j * C_0j, cofactor cut into four chunks
    always_comb
    begin
        logic signed [4*CH-1:0] ce;
        logic signed [CH:0]     chunk;
        for (int j = 0; j < 3; j++)
        begin
            ce = (4*CH)'(cof_reg[j]);
            for (int q = 0; q < 4; q++)
            begin
                if (q == 3)
                begin
                    chunk = $signed({ce[4*CH-1], ce[4*CH-1 -: CH]});
                end
                else
                begin
                    chunk = $signed({1'b0, ce[q*CH +: CH]});
                end
                dp_next[j][q] = row0_reg[2][j] * chunk;
            end
            dq_next[j][0] = DETW'(dp_reg[j][0]) + (DETW'(dp_reg[j][1]) <<< CH);
            dq_next[j][1] = DETW'(dp_reg[j][2]) + (DETW'(dp_reg[j][3]) <<< CH);
            term_next[j]  = dq_reg[j][0] + (dq_reg[j][1] <<< (2 * CH));
        end
        s01_next = term_reg[0] + term_reg[1];
        det_next = s01_reg + t2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            plo_reg     <= plo_next;
            phi_reg     <= phi_next;
            prod_reg    <= prod_next;
            cof_reg     <= cof_next;
            row0_reg[0] <= '{a_00, a_01, a_02};
            row0_reg[1] <= row0_reg[0];
            row0_reg[2] <= row0_reg[1];
            cofd_reg[0] <= cof_reg;
            for (int s = 1; s < 5; s++)
            begin
                cofd_reg[s] <= cofd_reg[s-1];
            end
            dp_reg      <= dp_next;
            dq_reg      <= dq_next;
            term_reg    <= term_next;
            s01_reg     <= s01_next;
            t2_reg      <= term_reg[2];
            det_reg     <= det_next;
        end
    end

    // divider lanes: inverse (i,j) takes cofactor (j,i)
    logic signed [W-1:0] inv_q [N];
    m3i_pkg::status_t    lane_st [N];
    logic [N-1:0]        lane_sat;

    for (genvar i = 0; i < 3; i++)
    begin : g_li
        for (genvar j = 0; j < 3; j++)
        begin : g_lj
            m3i_div #(
                .DATA_WIDTH (DATA_WIDTH),
                .FRAC_BITS  (FRAC_BITS)
            ) u_div (
                .clk    (clk),
                .adv    (adv),
                .num    (cofd_reg[4][j*3+i]),
                .den    (det_reg),
                .quo    (inv_q[i*3+j]),
                .status (lane_st[i*3+j])
            );
            assign lane_sat[i*3+j] = lane_st[i*3+j].saturated;
        end
    end

    assign inv_00    = inv_q[0];
    assign inv_01    = inv_q[1];
    assign inv_02    = inv_q[2];
    assign inv_10    = inv_q[3];
    assign inv_11    = inv_q[4];
    assign inv_12    = inv_q[5];
    assign inv_20    = inv_q[6];
    assign inv_21    = inv_q[7];
    assign inv_22    = inv_q[8];
    assign singular  = lane_st[0].singular;
    assign saturated = |lane_sat;

    // a singular result carries no clipping and zero diagonal entries
    a_singular_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && singular |-> !saturated && inv_00 == '0 && inv_11 == '0
                                  && inv_22 == '0)
        else $error("singular result with nonzero payload");

    // valid bits do not move while the pipeline is held
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg))
        else $error("valid pipeline moved during stall");

    // a valid entering the front end reaches the next stage on advance
    a_travel: assert property (@(posedge clk) disable iff (!rst_n)
        adv && vld_reg[0] |=> vld_reg[1])
        else $error("valid bit lost in front end");

    // the first and last lanes agree on the singular flag
    a_lanes: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> lane_st[0].singular == lane_st[8].singular)
        else $error("divider lanes disagree on singular");

endmodule

`default_nettype wire
